// ----- sv/bhtp_pkg.sv -----
`default_nettype none

package bhtp_pkg;

    // Field widths of one transfer.
    localparam int KEY_W      = 17;
    localparam int PAY_W      = 32;
    localparam int STATUS_W   = 3;
    localparam int BKT_OUT_W  = 3;
    localparam int SLOT_OUT_W = 2;

    // Default table geometry.
    localparam int BUCKETS_DEF = 8;
    localparam int SLOTS_DEF   = 3;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_FOUND    = 3'd0,
        ST_ABSENT   = 3'd1,
        ST_INSERTED = 3'd2,
        ST_PRESENT  = 3'd3,
        ST_FULL     = 3'd4
    } t_status;

    // Addresses of the control program.
    localparam int STEP_W = 4;
    typedef enum logic [STEP_W-1:0] {
        STEP_CLR        = 4'd0,
        STEP_IDLE       = 4'd1,
        STEP_QUOT       = 4'd2,
        STEP_REM        = 4'd3,
        STEP_BASE       = 4'd4,
        STEP_READ       = 4'd5,
        STEP_TEST_EMPTY = 4'd6,
        STEP_TEST_MATCH = 4'd7,
        STEP_ADVANCE    = 4'd8,
        STEP_FULL       = 4'd9,
        STEP_EMPTY      = 4'd10,
        STEP_HIT        = 4'd11
    } t_step;

    // Datapath action selected by a control word.
    typedef enum logic [3:0] {
        ACT_NONE    = 4'd0,
        ACT_CLEAR   = 4'd1,
        ACT_LOAD    = 4'd2,
        ACT_QUOT    = 4'd3,
        ACT_REM     = 4'd4,
        ACT_BASE    = 4'd5,
        ACT_READ    = 4'd6,
        ACT_ADVANCE = 4'd7,
        ACT_FULL    = 4'd8,
        ACT_EMPTY   = 4'd9,
        ACT_HIT     = 4'd10
    } t_act;

    // Jump condition: when true the sequencer goes to the target, else to the next step.
    typedef enum logic [2:0] {
        COND_NEVER      = 3'd0,
        COND_ALWAYS     = 3'd1,
        COND_CLR_MORE   = 3'd2,
        COND_WAIT       = 3'd3,
        COND_EMPTY      = 3'd4,
        COND_MATCH      = 3'd5,
        COND_PROBE_MORE = 3'd6
    } t_cond;

    // One control word of the program.
    typedef struct packed {
        t_act  act;
        t_cond cond;
        t_step target;
        logic  busy;
    } t_uword;

    // The control program, one word per step.
    function automatic t_uword ucode_rom(input t_step step);
        t_uword w;
        unique case (step)
            STEP_CLR:        w = '{ACT_CLEAR,   COND_CLR_MORE,   STEP_CLR,   1'b1};
            STEP_IDLE:       w = '{ACT_LOAD,    COND_WAIT,       STEP_IDLE,  1'b0};
            STEP_QUOT:       w = '{ACT_QUOT,    COND_NEVER,      STEP_IDLE,  1'b1};
            STEP_REM:        w = '{ACT_REM,     COND_NEVER,      STEP_IDLE,  1'b1};
            STEP_BASE:       w = '{ACT_BASE,    COND_NEVER,      STEP_IDLE,  1'b1};
            STEP_READ:       w = '{ACT_READ,    COND_NEVER,      STEP_IDLE,  1'b1};
            STEP_TEST_EMPTY: w = '{ACT_NONE,    COND_EMPTY,      STEP_EMPTY, 1'b1};
            STEP_TEST_MATCH: w = '{ACT_NONE,    COND_MATCH,      STEP_HIT,   1'b1};
            STEP_ADVANCE:    w = '{ACT_ADVANCE, COND_PROBE_MORE, STEP_READ,  1'b1};
            STEP_FULL:       w = '{ACT_FULL,    COND_ALWAYS,     STEP_IDLE,  1'b1};
            STEP_EMPTY:      w = '{ACT_EMPTY,   COND_ALWAYS,     STEP_IDLE,  1'b1};
            STEP_HIT:        w = '{ACT_HIT,     COND_ALWAYS,     STEP_IDLE,  1'b1};
            default:         w = '{ACT_NONE,    COND_ALWAYS,     STEP_IDLE,  1'b1};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ----- sv/bucketed_hash_table_probe.sv -----
`default_nettype none

// Channel   Direction  Handshake                  Payload
// command   in         start high, busy low       i_operation, i_key, i_payload
// result    out        o_valid for one cycle      o_status, o_bucket_index,
//                                                 o_slot_index, o_found_payload
//
// After reset the block sweeps the slot memory once, one slot per cycle,
// and holds busy high meanwhile.
// A command holds busy high until its probe ends on an empty slot or on a match,
// or until it has passed over every slot of a full table. The key remainder is
// found by a reciprocal multiply step and then a multiply-subtract step, and
// each slot costs a four-step loop of the sequencer around the memory read.
// The result appears the cycle after the last step, while busy is already low;
// the receiver cannot stall, so every result is taken in that cycle.

module bucketed_hash_table_probe #(
    parameter int BUCKETS          = bhtp_pkg::BUCKETS_DEF,
    parameter int SLOTS_PER_BUCKET = bhtp_pkg::SLOTS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic                            i_operation,
    input  wire logic [bhtp_pkg::KEY_W-1:0]      i_key,
    input  wire logic [bhtp_pkg::PAY_W-1:0]      i_payload,
    output logic                                 o_valid,
    output logic      [bhtp_pkg::STATUS_W-1:0]   o_status,
    output logic      [bhtp_pkg::BKT_OUT_W-1:0]  o_bucket_index,
    output logic      [bhtp_pkg::SLOT_OUT_W-1:0] o_slot_index,
    output logic      [bhtp_pkg::PAY_W-1:0]      o_found_payload
);

    localparam int TOTAL   = BUCKETS * SLOTS_PER_BUCKET;
    localparam int AW      = (TOTAL > 1) ? $clog2(TOTAL) : 1;
    localparam int BW      = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int SW      = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
    localparam int ENTRY_W = 1 + bhtp_pkg::KEY_W + bhtp_pkg::PAY_W;

    // Reciprocal of BUCKETS, rounded up, exact for every key of KEY_W bits.
    localparam int     RECIP_SH = bhtp_pkg::KEY_W + $clog2(BUCKETS);
    localparam int     RECIP_W  = bhtp_pkg::KEY_W + 1;
    localparam int     PROD_W   = bhtp_pkg::KEY_W + RECIP_W;
    localparam longint RECIP    = ((longint'(1) << RECIP_SH) + longint'(BUCKETS)
                                   - longint'(1)) / longint'(BUCKETS);

    // Sequencer state.
    bhtp_pkg::t_step  r_step, n_step;
    bhtp_pkg::t_uword uw;
    logic             take;

    // Datapath registers.
    logic                           r_op, n_op;
    logic [bhtp_pkg::KEY_W-1:0]     r_key, n_key;
    logic [bhtp_pkg::PAY_W-1:0]     r_pay, n_pay;
    logic [bhtp_pkg::KEY_W-1:0]     r_quo, n_quo;
    logic [BW-1:0]                  r_bkt, n_bkt;
    logic [SW-1:0]                  r_slot, n_slot;
    logic [BW-1:0]                  r_nvis, n_nvis;
    logic [AW-1:0]                  r_addr, n_addr;
    logic [AW-1:0]                  r_clr, n_clr;

    // Result registers.
    logic                           r_valid, n_valid;
    bhtp_pkg::t_status              r_status, n_status;
    logic [bhtp_pkg::BKT_OUT_W-1:0] r_bidx, n_bidx;
    logic [bhtp_pkg::SLOT_OUT_W-1:0] r_sidx, n_sidx;
    logic [bhtp_pkg::PAY_W-1:0]     r_fpay, n_fpay;

    // Memory port signals.
    logic                 mem_we, mem_re;
    logic [AW-1:0]        mem_waddr;
    logic [ENTRY_W-1:0]   mem_wdata, mem_rdata;

    // Slot fields and probe flags.
    logic                        e_valid;
    logic [bhtp_pkg::KEY_W-1:0]  e_key;
    logic [bhtp_pkg::PAY_W-1:0]  e_pay;
    logic                        e_match;
    logic                        last_slot, last_bkt, last_visit;

    // Home bucket arithmetic.
    logic [PROD_W-1:0]           quo_prod, quo_sh;
    logic [bhtp_pkg::KEY_W-1:0]  rem_full;

    // Slot memory: valid bit, key and payload in one word.
    bhtp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TOTAL)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (r_addr),
        .o_rdata (mem_rdata)
    );

    assign e_valid = mem_rdata[ENTRY_W-1];
    assign e_key   = mem_rdata[bhtp_pkg::PAY_W +: bhtp_pkg::KEY_W];
    assign e_pay   = mem_rdata[bhtp_pkg::PAY_W-1:0];
    assign e_match = e_valid && (e_key == r_key);

    assign last_slot  = (r_slot == SW'(SLOTS_PER_BUCKET - 1));
    assign last_bkt   = (r_bkt == BW'(BUCKETS - 1));
    assign last_visit = (r_nvis == BW'(BUCKETS - 1));

    // Quotient of the key by BUCKETS from a reciprocal multiply, then the remainder.
    assign quo_prod = PROD_W'(r_key) * PROD_W'(RECIP);
    assign quo_sh   = quo_prod >> RECIP_SH;
    assign rem_full = r_key - r_quo * bhtp_pkg::KEY_W'(BUCKETS);

    // Control word of the current step.
    always_comb begin
        uw = bhtp_pkg::ucode_rom(r_step);
    end

    // Next step: jump on the selected condition, otherwise fall through.
    always_comb begin
        unique case (uw.cond)
            bhtp_pkg::COND_NEVER:      take = 1'b0;
            bhtp_pkg::COND_ALWAYS:     take = 1'b1;
            bhtp_pkg::COND_CLR_MORE:   take = (r_clr != AW'(TOTAL - 1));
            bhtp_pkg::COND_WAIT:       take = !start;
            bhtp_pkg::COND_EMPTY:      take = !e_valid;
            bhtp_pkg::COND_MATCH:      take = e_match;
            bhtp_pkg::COND_PROBE_MORE: take = !(last_slot && last_visit);
            default:                   take = 1'b1;
        endcase
        n_step = take ? uw.target : bhtp_pkg::t_step'(r_step + 4'd1);
    end

    // Datapath driven by the action of the control word.
    always_comb begin
        n_op      = r_op;
        n_key     = r_key;
        n_pay     = r_pay;
        n_quo     = r_quo;
        n_bkt     = r_bkt;
        n_slot    = r_slot;
        n_nvis    = r_nvis;
        n_addr    = r_addr;
        n_clr     = r_clr;
        n_valid   = 1'b0;
        n_status  = r_status;
        n_bidx    = r_bidx;
        n_sidx    = r_sidx;
        n_fpay    = r_fpay;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_waddr = r_addr;
        mem_wdata = '0;

        case (uw.act)
            bhtp_pkg::ACT_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                n_clr     = r_clr + 1'b1;
            end
            bhtp_pkg::ACT_LOAD: begin
                if (start) begin
                    n_op  = i_operation;
                    n_key = i_key;
                    n_pay = i_payload;
                end
            end
            bhtp_pkg::ACT_QUOT: begin
                n_quo = quo_sh[bhtp_pkg::KEY_W-1:0];
            end
            bhtp_pkg::ACT_REM: begin
                // The remainder is below BUCKETS, so it fits the bucket index.
                n_bkt = rem_full[BW-1:0];
            end
            bhtp_pkg::ACT_BASE: begin
                n_addr = AW'(r_bkt * SLOTS_PER_BUCKET);
                n_slot = '0;
                n_nvis = '0;
            end
            bhtp_pkg::ACT_READ: begin
                mem_re = 1'b1;
            end
            bhtp_pkg::ACT_ADVANCE: begin
                // Buckets lie back to back, so the address just steps and wraps.
                n_addr = (r_addr == AW'(TOTAL - 1)) ? '0 : r_addr + 1'b1;
                if (last_slot) begin
                    n_slot = '0;
                    n_bkt  = last_bkt ? '0 : r_bkt + 1'b1;
                    n_nvis = r_nvis + 1'b1;
                end else begin
                    n_slot = r_slot + 1'b1;
                end
            end
            bhtp_pkg::ACT_FULL: begin
                n_valid  = 1'b1;
                n_status = r_op ? bhtp_pkg::ST_FULL : bhtp_pkg::ST_ABSENT;
                n_bidx   = '0;
                n_sidx   = '0;
                n_fpay   = '0;
            end
            bhtp_pkg::ACT_EMPTY: begin
                // An insert claims the empty slot where the probe stopped.
                mem_we    = r_op;
                mem_wdata = {1'b1, r_key, r_pay};
                n_valid   = 1'b1;
                n_status  = r_op ? bhtp_pkg::ST_INSERTED : bhtp_pkg::ST_ABSENT;
                n_bidx    = bhtp_pkg::BKT_OUT_W'(r_bkt);
                n_sidx    = bhtp_pkg::SLOT_OUT_W'(r_slot);
                n_fpay    = '0;
            end
            bhtp_pkg::ACT_HIT: begin
                n_valid  = 1'b1;
                n_status = r_op ? bhtp_pkg::ST_PRESENT : bhtp_pkg::ST_FOUND;
                n_bidx   = bhtp_pkg::BKT_OUT_W'(r_bkt);
                n_sidx   = bhtp_pkg::SLOT_OUT_W'(r_slot);
                n_fpay   = e_pay;
            end
            default: begin
            end
        endcase
    end

    // Control registers with reset; the clearing sweep starts from slot zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= bhtp_pkg::STEP_CLR;
            r_clr   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_step  <= n_step;
            r_clr   <= n_clr;
            r_valid <= n_valid;
        end
    end

    // Datapath and result registers.
    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_key    <= n_key;
        r_pay    <= n_pay;
        r_quo    <= n_quo;
        r_bkt    <= n_bkt;
        r_slot   <= n_slot;
        r_nvis   <= n_nvis;
        r_addr   <= n_addr;
        r_status <= n_status;
        r_bidx   <= n_bidx;
        r_sidx   <= n_sidx;
        r_fpay   <= n_fpay;
    end

    assign busy            = uw.busy;
    assign o_valid         = r_valid;
    assign o_status        = r_status;
    assign o_bucket_index  = r_bidx;
    assign o_slot_index    = r_sidx;
    assign o_found_payload = r_fpay;

    // A result strobe follows one of the three response steps.
    a_valid_from_response: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(r_step) == bhtp_pkg::STEP_FULL
                  || $past(r_step) == bhtp_pkg::STEP_EMPTY
                  || $past(r_step) == bhtp_pkg::STEP_HIT))
        else $error("result strobe without a response step");

    // Results are never produced in back-to-back cycles.
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("two result strobes in a row");

    // The memory is written only by the clearing sweep or by an insert into an empty slot.
    a_write_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_step == bhtp_pkg::STEP_CLR
                 || (r_step == bhtp_pkg::STEP_EMPTY && r_op)))
        else $error("unexpected slot memory write");

    // While probing, the slot index stays inside its bucket.
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == bhtp_pkg::STEP_TEST_EMPTY) |-> (r_slot <= SW'(SLOTS_PER_BUCKET - 1)))
        else $error("slot index beyond bucket");

endmodule

`default_nettype wire

// ----- sv/bhtp_ram.sv -----
`default_nettype none

module bhtp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- verif/tb_bucketed_hash_table_probe.sv -----
`timescale 1ns / 100ps

module tb_bucketed_hash_table_probe;

    // Table geometry of the instance under test.
    localparam int NBKT   = bhtp_pkg::BUCKETS_DEF;
    localparam int NSLOT  = bhtp_pkg::SLOTS_DEF;
    localparam int NTOTAL = NBKT * NSLOT;

    localparam logic OP_SEARCH = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    localparam int KEY_MAX       = (1 << bhtp_pkg::KEY_W) - 1;
    localparam int RANDOM_ITEMS  = 900;
    localparam int MAX_GAP       = 12;
    // Slowest command is a probe through a full table.
    localparam int DRAIN_CYCLES  = 4 + 4 * NTOTAL + 16;
    localparam int WATCHDOG_MAX  = 1000;
    localparam int NUM_DIRECTED  = 20;
    localparam int QUIET_FIRST   = 300;
    localparam int QUIET_LAST    = 450;

    // Probe progress inside the predictor.
    typedef enum int {PR_SEARCHING, PR_MATCH, PR_EMPTY, PR_FULL} t_probe;

    typedef struct packed {
        bhtp_pkg::t_status                   status;
        logic [bhtp_pkg::BKT_OUT_W-1:0]      bucket;
        logic [bhtp_pkg::SLOT_OUT_W-1:0]     slot;
        logic [bhtp_pkg::PAY_W-1:0]          payload;
    } t_result;

    typedef struct packed {
        logic                       op;
        logic [bhtp_pkg::KEY_W-1:0] key;
        logic [bhtp_pkg::PAY_W-1:0] pay;
        logic                       typed;
        t_result                    res;
    } t_row;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       start = 1'b0;
    logic                       i_operation = 1'b0;
    logic [bhtp_pkg::KEY_W-1:0] i_key = '0;
    logic [bhtp_pkg::PAY_W-1:0] i_payload = '0;
    wire                        busy;
    wire                        o_valid;
    wire [bhtp_pkg::STATUS_W-1:0]   o_status;
    wire [bhtp_pkg::BKT_OUT_W-1:0]  o_bucket_index;
    wire [bhtp_pkg::SLOT_OUT_W-1:0] o_slot_index;
    wire [bhtp_pkg::PAY_W-1:0]      o_found_payload;

    // Shadow copy of the slot memory.
    logic                       tbl_valid [NTOTAL];
    logic [bhtp_pkg::KEY_W-1:0] tbl_key [NTOTAL];
    logic [bhtp_pkg::PAY_W-1:0] tbl_payload [NTOTAL];

    t_result                    expected_results [$];
    logic [bhtp_pkg::KEY_W-1:0] stored_keys [$];
    t_row                       directed_rows [NUM_DIRECTED];

    int  errors = 0;
    int  commands_sent = 0;
    int  inserts_sent = 0;
    int  results_checked = 0;
    int  idle_cycles = 0;
    int  status_count [5];
    bit  idling_on = 1'b1;

    bucketed_hash_table_probe u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_operation     (i_operation),
        .i_key           (i_key),
        .i_payload       (i_payload),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_bucket_index  (o_bucket_index),
        .o_slot_index    (o_slot_index),
        .o_found_payload (o_found_payload)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Probe the shadow table for one command, apply an insert, return the result.
    function automatic t_result probe_table(input logic op,
                                            input logic [bhtp_pkg::KEY_W-1:0] key,
                                            input logic [bhtp_pkg::PAY_W-1:0] pay);
        t_result r;
        t_probe  outcome;
        int      bkt;
        int      slot;
        int      idx;
        int      hops;
        outcome = PR_SEARCHING;
        bkt = int'(key) % NBKT;
        slot = 0;
        hops = 0;
        while (outcome == PR_SEARCHING && hops < NBKT) begin
            slot = 0;
            while (outcome == PR_SEARCHING && slot < NSLOT) begin
                idx = bkt * NSLOT + slot;
                if (!tbl_valid[idx])
                    outcome = PR_EMPTY;
                else if (tbl_key[idx] == key)
                    outcome = PR_MATCH;
                else
                    slot++;
            end
            if (outcome == PR_SEARCHING) begin
                bkt = (bkt + 1 == NBKT) ? 0 : bkt + 1;
                hops++;
            end
        end
        if (outcome == PR_SEARCHING) begin
            outcome = PR_FULL;
            bkt = 0;
            slot = 0;
        end
        idx = bkt * NSLOT + slot;
        r.payload = '0;
        case (outcome)
            PR_MATCH: begin
                r.status = (op == OP_INSERT) ? bhtp_pkg::ST_PRESENT : bhtp_pkg::ST_FOUND;
                r.payload = tbl_payload[idx];
            end
            PR_EMPTY: begin
                if (op == OP_INSERT) begin
                    tbl_valid[idx] = 1'b1;
                    tbl_key[idx] = key;
                    tbl_payload[idx] = pay;
                    r.status = bhtp_pkg::ST_INSERTED;
                end else begin
                    r.status = bhtp_pkg::ST_ABSENT;
                end
            end
            default: begin
                r.status = (op == OP_INSERT) ? bhtp_pkg::ST_FULL : bhtp_pkg::ST_ABSENT;
            end
        endcase
        r.bucket = bkt[bhtp_pkg::BKT_OUT_W-1:0];
        r.slot = slot[bhtp_pkg::SLOT_OUT_W-1:0];
        return r;
    endfunction

    // Hold start low for a random number of cycles.
    task automatic sender_pause();
        int gap;
        gap = 0;
        while (idling_on && gap < MAX_GAP && $urandom_range(99) < 27) begin
            start <= 1'b0;
            @(posedge i_clk);
            gap++;
        end
    endtask

    // Present one command, wait for its transfer, and record the expected result.
    task automatic send_command(input logic op, input logic [bhtp_pkg::KEY_W-1:0] key,
                                input logic [bhtp_pkg::PAY_W-1:0] pay, input logic typed,
                                input t_result typed_res);
        t_result predicted;
        start <= 1'b1;
        i_operation <= op;
        i_key <= key;
        i_payload <= pay;
        do @(posedge i_clk); while (busy !== 1'b0);
        predicted = probe_table(op, key, pay);
        expected_results.push_back(typed ? typed_res : predicted);
        if (predicted.status == bhtp_pkg::ST_INSERTED)
            stored_keys.push_back(key);
        commands_sent++;
        if (op == OP_INSERT)
            inserts_sent++;
    endtask

    // Compare every result transfer with the oldest expectation.
    always @(posedge i_clk) begin
        t_result exp_res;
        if (i_rst_n && o_valid === 1'b1) begin
            if (expected_results.size() == 0) begin
                $error("result with no command outstanding: status %0d", o_status);
                errors++;
            end else begin
                exp_res = expected_results.pop_front();
                results_checked++;
                if (o_status < 5)
                    status_count[o_status]++;
                if (o_status !== exp_res.status) begin
                    $error("status expected %0d actual %0d", exp_res.status, o_status);
                    errors++;
                end
                if (o_bucket_index !== exp_res.bucket) begin
                    $error("bucket_index expected %0d actual %0d",
                           exp_res.bucket, o_bucket_index);
                    errors++;
                end
                if (o_slot_index !== exp_res.slot) begin
                    $error("slot_index expected %0d actual %0d", exp_res.slot, o_slot_index);
                    errors++;
                end
                if (o_found_payload !== exp_res.payload) begin
                    $error("found_payload expected %h actual %h",
                           exp_res.payload, o_found_payload);
                    errors++;
                end
            end
        end
    end

    // Count cycles in which no transfer happens on either side.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && busy === 1'b0) || o_valid === 1'b1)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin : watchdog
        while (idle_cycles < WATCHDOG_MAX)
            @(posedge i_clk);
        $display("tb_bucketed_hash_table_probe NOT OK");
        $finish;
    end

    initial begin : stimulus
        logic                       op;
        logic [bhtp_pkg::KEY_W-1:0] key;
        int                         pick;
        t_result                    none;

        none = '0;
        for (int i = 0; i < NTOTAL; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_key[i] = '0;
            tbl_payload[i] = '0;
        end
        for (int i = 0; i < 5; i++)
            status_count[i] = 0;

        // Directed commands; typed results are the obvious ones near reset and at extremes.
        directed_rows[0]  = '{OP_SEARCH, 17'd0, 32'd0, 1'b1,
                              '{bhtp_pkg::ST_ABSENT, 3'd0, 2'd0, 32'd0}};
        directed_rows[1]  = '{OP_INSERT, 17'd0, 32'd0, 1'b1,
                              '{bhtp_pkg::ST_INSERTED, 3'd0, 2'd0, 32'd0}};
        directed_rows[2]  = '{OP_INSERT, 17'h1FFFF, 32'hFFFF_FFFF, 1'b1,
                              '{bhtp_pkg::ST_INSERTED, 3'd7, 2'd0, 32'd0}};
        directed_rows[3]  = '{OP_SEARCH, 17'h1FFFF, 32'd0, 1'b1,
                              '{bhtp_pkg::ST_FOUND, 3'd7, 2'd0, 32'hFFFF_FFFF}};
        directed_rows[4]  = '{OP_SEARCH, 17'd0, 32'hFFFF_FFFF, 1'b1,
                              '{bhtp_pkg::ST_FOUND, 3'd0, 2'd0, 32'd0}};
        directed_rows[5]  = '{OP_INSERT, 17'd0, 32'hFFFF_FFFF, 1'b1,
                              '{bhtp_pkg::ST_PRESENT, 3'd0, 2'd0, 32'd0}};
        // Fill bucket 0 and then spill into bucket 1.
        directed_rows[6]  = '{OP_INSERT, 17'd8, 32'hA5A5_A5A5, 1'b0, none};
        directed_rows[7]  = '{OP_INSERT, 17'd16, 32'h5A5A_5A5A, 1'b0, none};
        directed_rows[8]  = '{OP_INSERT, 17'd24, 32'h1234_5678, 1'b0, none};
        directed_rows[9]  = '{OP_SEARCH, 17'd24, 32'd0, 1'b0, none};
        // Fill the last bucket so the next probe wraps to bucket 0.
        directed_rows[10] = '{OP_INSERT, 17'd15, 32'h0000_0001, 1'b0, none};
        directed_rows[11] = '{OP_INSERT, 17'd23, 32'h8000_0000, 1'b0, none};
        directed_rows[12] = '{OP_INSERT, 17'd31, 32'hDEAD_BEEF, 1'b0, none};
        directed_rows[13] = '{OP_SEARCH, 17'd31, 32'd0, 1'b0, none};
        // Misses that stop on an empty slot after skipping full buckets, then further inserts and searches.
        directed_rows[14] = '{OP_SEARCH, 17'd32, 32'd0, 1'b0, none};
        directed_rows[15] = '{OP_SEARCH, 17'd7, 32'hFFFF_FFFF, 1'b0, none};
        directed_rows[16] = '{OP_INSERT, 17'h1FFFF, 32'd0, 1'b1,
                              '{bhtp_pkg::ST_PRESENT, 3'd7, 2'd0, 32'hFFFF_FFFF}};
        directed_rows[17] = '{OP_SEARCH, 17'd1, 32'hFFFF_FFFF, 1'b0, none};
        directed_rows[18] = '{OP_INSERT, 17'h1AAAA, 32'h5555_5555, 1'b0, none};
        directed_rows[19] = '{OP_SEARCH, 17'h15555, 32'hAAAA_AAAA, 1'b0, none};

        // Hold synchronous reset, then release it.
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < NUM_DIRECTED; i++) begin
            sender_pause();
            send_command(directed_rows[i].op, directed_rows[i].key, directed_rows[i].pay,
                         directed_rows[i].typed, directed_rows[i].res);
        end

        // Random commands: mostly keys already stored or small keys that collide,
        // so the table fills up and probes run long; the rest span the whole key range.
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            idling_on = (i < QUIET_FIRST || i >= QUIET_LAST);
            op = ($urandom_range(99) < 45) ? OP_INSERT : OP_SEARCH;
            pick = $urandom_range(99);
            if (stored_keys.size() != 0 && pick < 45)
                key = stored_keys[$urandom_range(stored_keys.size() - 1)];
            else if (pick < 70)
                key = (bhtp_pkg::KEY_W)'($urandom_range(4 * NBKT - 1));
            else
                key = (bhtp_pkg::KEY_W)'($urandom_range(KEY_MAX));
            sender_pause();
            send_command(op, key, $urandom, 1'b0, none);
        end
        start <= 1'b0;

        // Let the last results come out, then give the block time for stray ones.
        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d commands (%0d inserts), checked %0d results.",
                 commands_sent, inserts_sent, results_checked);
        $display("Statuses: found %0d, absent %0d, inserted %0d, present %0d, full %0d.",
                 status_count[bhtp_pkg::ST_FOUND], status_count[bhtp_pkg::ST_ABSENT],
                 status_count[bhtp_pkg::ST_INSERTED], status_count[bhtp_pkg::ST_PRESENT],
                 status_count[bhtp_pkg::ST_FULL]);
        if (errors == 0 && expected_results.size() == 0)
            $display("tb_bucketed_hash_table_probe OK");
        else
            $display("tb_bucketed_hash_table_probe NOT OK");
        $finish;
    end

endmodule
